[src/fdfc_pkg.sv]
// Shared types, constants and the helper function for the fan duty failsafe controller.
package fdfc_pkg;

  // PWM compare range; the compare value is inverted, PWM_FULL means off
  localparam int unsigned PWM_FULL  = 255;
  localparam int unsigned RAW_W     = 8;
  localparam int unsigned PCT_W     = 7;
  localparam int unsigned PCT_MAX   = 100;
  localparam int unsigned NEAR_OFF  = 5;
  localparam int unsigned TICK_W    = 16;
  localparam int unsigned LEASE_W   = 20;

  // reciprocal of 100 for the percent to compare value scaling
  localparam int unsigned RECIP_SH  = 22;
  localparam int unsigned RECIP     = (2**RECIP_SH + PCT_MAX - 1) / PCT_MAX;
  localparam int unsigned NUM_W     = 16;

  localparam logic [RAW_W-1:0] RAW_OFF      = RAW_W'(PWM_FULL);
  localparam logic [RAW_W-1:0] RAW_FULL     = '0;
  localparam logic [RAW_W-1:0] RAW_NEAR_OFF = RAW_W'(PWM_FULL - NEAR_OFF);
  localparam logic [PCT_W-1:0] PCT_FULL     = PCT_W'(PCT_MAX);

  // configuration register map
  localparam int unsigned CFG_AW = 5;
  localparam logic [2:0] REG_MIN_START = 3'd0;
  localparam logic [2:0] REG_MIN_RUN   = 3'd1;
  localparam logic [2:0] REG_KICK_PCT  = 3'd2;
  localparam logic [2:0] REG_KICK_TCK  = 3'd3;
  localparam logic [2:0] REG_LEASE_TCK = 3'd4;
  localparam logic [2:0] REG_IDENT_TCK = 3'd5;
  localparam logic [2:0] REG_BLINK_TCK = 3'd6;
  localparam logic [2:0] REG_WATCHDOG  = 3'd7;

  // item opcodes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_IDENT = 2'd2;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_SET_OK    = 3'd1,
    EV_RANGE     = 3'd2,
    EV_NO_WDOG   = 3'd3,
    EV_LEASE_EXP = 3'd4
  } event_t;

  typedef struct packed {
    logic [PCT_W-1:0]   min_start_pct;
    logic [PCT_W-1:0]   min_run_pct;
    logic [PCT_W-1:0]   kick_pct;
    logic [TICK_W-1:0]  kick_ticks;
    logic [LEASE_W-1:0] lease_ticks;
    logic [TICK_W-1:0]  identify_ticks;
    logic [TICK_W-1:0]  blink_ticks;
    logic               watchdog_ok;
  } cfg_t;

  // compare value for a percent, clamped to 100: PWM_FULL - floor(p * PWM_FULL / 100)
  function automatic logic [RAW_W-1:0] pct_raw(input logic [PCT_W-1:0] p);
    logic [PCT_W-1:0] pc;
    logic [NUM_W-1:0] num;
    logic [31:0]      prod;
    pc   = (p > PCT_FULL) ? PCT_FULL : p;
    num  = NUM_W'(pc) * NUM_W'(PWM_FULL);
    prod = 32'(num) * 32'(RECIP);
    return RAW_OFF - prod[RECIP_SH +: RAW_W];
  endfunction

endpackage

[src/fdfc_in_if.sv]
// Input channel: one tick, set or identify command per beat.
interface fdfc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] percent_value;

  modport source (output valid, output opcode, output percent_value, input ready);
  modport sink   (input valid, input opcode, input percent_value, output ready);
endinterface

[src/fdfc_out_if.sv]
// Result channel: controller status after each command beat.
interface fdfc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] applied_raw;
  logic [6:0] demand_pct;
  logic       failsafe_on;
  logic       kick_on;
  logic       identify_on;
  logic       identify_led;
  logic [2:0] event_code;

  modport source (output valid, output applied_raw, output demand_pct, output failsafe_on,
                  output kick_on, output identify_on, output identify_led,
                  output event_code, input ready);
  modport sink   (input valid, input applied_raw, input demand_pct, input failsafe_on,
                  input kick_on, input identify_on, input identify_led,
                  input event_code, output ready);
endinterface

[src/fdfc_cfg.sv]
// APB-style configuration register file.
module fdfc_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fdfc_pkg::CFG_AW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output fdfc_pkg::cfg_t                cfg
);

  fdfc_pkg::cfg_t cfg_r;
  logic           wr_en;
  logic [2:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_start_pct  <= fdfc_pkg::PCT_W'(22);
      cfg_r.min_run_pct    <= fdfc_pkg::PCT_W'(18);
      cfg_r.kick_pct       <= fdfc_pkg::PCT_W'(85);
      cfg_r.kick_ticks     <= fdfc_pkg::TICK_W'(500);
      cfg_r.lease_ticks    <= fdfc_pkg::LEASE_W'(60000);
      cfg_r.identify_ticks <= fdfc_pkg::TICK_W'(10000);
      cfg_r.blink_ticks    <= fdfc_pkg::TICK_W'(250);
      cfg_r.watchdog_ok    <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        fdfc_pkg::REG_MIN_START: cfg_r.min_start_pct  <= pwdata[fdfc_pkg::PCT_W-1:0];
        fdfc_pkg::REG_MIN_RUN:   cfg_r.min_run_pct    <= pwdata[fdfc_pkg::PCT_W-1:0];
        fdfc_pkg::REG_KICK_PCT:  cfg_r.kick_pct       <= pwdata[fdfc_pkg::PCT_W-1:0];
        fdfc_pkg::REG_KICK_TCK:  cfg_r.kick_ticks     <= pwdata[fdfc_pkg::TICK_W-1:0];
        fdfc_pkg::REG_LEASE_TCK: cfg_r.lease_ticks    <= pwdata[fdfc_pkg::LEASE_W-1:0];
        fdfc_pkg::REG_IDENT_TCK: cfg_r.identify_ticks <= pwdata[fdfc_pkg::TICK_W-1:0];
        fdfc_pkg::REG_BLINK_TCK: cfg_r.blink_ticks    <= pwdata[fdfc_pkg::TICK_W-1:0];
        fdfc_pkg::REG_WATCHDOG:  cfg_r.watchdog_ok    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      fdfc_pkg::REG_MIN_START: prdata = 32'(cfg_r.min_start_pct);
      fdfc_pkg::REG_MIN_RUN:   prdata = 32'(cfg_r.min_run_pct);
      fdfc_pkg::REG_KICK_PCT:  prdata = 32'(cfg_r.kick_pct);
      fdfc_pkg::REG_KICK_TCK:  prdata = 32'(cfg_r.kick_ticks);
      fdfc_pkg::REG_LEASE_TCK: prdata = 32'(cfg_r.lease_ticks);
      fdfc_pkg::REG_IDENT_TCK: prdata = 32'(cfg_r.identify_ticks);
      fdfc_pkg::REG_BLINK_TCK: prdata = 32'(cfg_r.blink_ticks);
      fdfc_pkg::REG_WATCHDOG:  prdata = 32'(cfg_r.watchdog_ok);
      default: ;
    endcase
  end

endmodule

[src/fdfc_core.sv]
// Input register, controller state update and result register.
module fdfc_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fdfc_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_opcode,
  input  logic [7:0]                    in_percent,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fdfc_pkg::RAW_W-1:0]    out_applied_raw,
  output logic [fdfc_pkg::PCT_W-1:0]    out_demand_pct,
  output logic                          out_failsafe_on,
  output logic                          out_kick_on,
  output logic                          out_identify_on,
  output logic                          out_identify_led,
  output logic [2:0]                    out_event_code
);

  localparam int unsigned RW = fdfc_pkg::RAW_W;
  localparam int unsigned PW = fdfc_pkg::PCT_W;
  localparam int unsigned TW = fdfc_pkg::TICK_W;
  localparam int unsigned LW = fdfc_pkg::LEASE_W;

  // input stage
  logic             in_valid_r;
  logic [1:0]       in_op_r;
  logic [7:0]       in_pct_r;
  logic             advance;

  // controller state
  logic [RW-1:0]    applied_r,   applied_nxt;
  logic [PW-1:0]    setpoint_r,  setpoint_nxt;
  logic [RW-1:0]    kick_tgt_r,  kick_tgt_nxt;
  logic             kick_pend_r, kick_pend_nxt;
  logic [TW-1:0]    kick_el_r,   kick_el_nxt;
  logic [LW-1:0]    lease_el_r,  lease_el_nxt;
  logic             has_ctl_r,   has_ctl_nxt;
  logic             failsafe_r,  failsafe_nxt;
  logic             ident_run_r, ident_run_nxt;
  logic             ident_led_r, ident_led_nxt;
  logic [TW-1:0]    ident_el_r,  ident_el_nxt;
  logic [TW-1:0]    blink_el_r,  blink_el_nxt;
  fdfc_pkg::event_t ev_nxt;

  // result stage
  logic             out_valid_r;
  logic [2:0]       event_r;

  // set path helpers
  logic [PW-1:0]    set_val;
  logic             near_off;
  logic [PW-1:0]    lo_pct;
  logic [PW-1:0]    adj_pct;
  logic [RW-1:0]    adj_raw;
  logic [RW-1:0]    kick_raw;

  // tick path helpers
  logic [TW-1:0]    kick_inc;
  logic [TW-1:0]    ident_inc;
  logic [TW-1:0]    blink_inc;
  logic [LW-1:0]    lease_inc;

  assign advance  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_op_r  <= in_opcode;
      in_pct_r <= in_percent;
    end
  end

  assign set_val  = in_pct_r[PW-1:0];
  assign near_off = kick_pend_r || (applied_r >= fdfc_pkg::RAW_NEAR_OFF);
  assign lo_pct   = near_off ? cfg.min_start_pct : cfg.min_run_pct;
  assign adj_pct  = (set_val < lo_pct) ? lo_pct : set_val;
  assign adj_raw  = fdfc_pkg::pct_raw(adj_pct);
  assign kick_raw = fdfc_pkg::pct_raw(cfg.kick_pct);

  // saturating counters
  assign kick_inc  = (&kick_el_r)  ? kick_el_r  : kick_el_r  + TW'(1);
  assign ident_inc = (&ident_el_r) ? ident_el_r : ident_el_r + TW'(1);
  assign blink_inc = (&blink_el_r) ? blink_el_r : blink_el_r + TW'(1);
  assign lease_inc = (&lease_el_r) ? lease_el_r : lease_el_r + LW'(1);

  always_comb begin
    applied_nxt   = applied_r;
    setpoint_nxt  = setpoint_r;
    kick_tgt_nxt  = kick_tgt_r;
    kick_pend_nxt = kick_pend_r;
    kick_el_nxt   = kick_el_r;
    lease_el_nxt  = lease_el_r;
    has_ctl_nxt   = has_ctl_r;
    failsafe_nxt  = failsafe_r;
    ident_run_nxt = ident_run_r;
    ident_led_nxt = ident_led_r;
    ident_el_nxt  = ident_el_r;
    blink_el_nxt  = blink_el_r;
    ev_nxt        = fdfc_pkg::EV_NONE;

    unique case (in_op_r)
      fdfc_pkg::OP_TICK: begin
        if (kick_pend_r) begin
          if (kick_inc >= cfg.kick_ticks) begin
            applied_nxt   = kick_tgt_r;
            kick_pend_nxt = 1'b0;
            kick_el_nxt   = '0;
          end else begin
            kick_el_nxt   = kick_inc;
          end
        end
        if (ident_run_r) begin
          ident_el_nxt = ident_inc;
          if (ident_inc >= cfg.identify_ticks) begin
            ident_run_nxt = 1'b0;
            ident_led_nxt = 1'b0;
          end else if (blink_inc >= cfg.blink_ticks) begin
            blink_el_nxt  = '0;
            ident_led_nxt = !ident_led_r;
          end else begin
            blink_el_nxt  = blink_inc;
          end
        end
        if (has_ctl_r && !failsafe_r) begin
          lease_el_nxt = lease_inc;
          // lease ran out: drop to full speed, cancel any kick
          if (lease_inc > cfg.lease_ticks) begin
            failsafe_nxt  = 1'b1;
            setpoint_nxt  = fdfc_pkg::PCT_FULL;
            kick_pend_nxt = 1'b0;
            kick_el_nxt   = '0;
            applied_nxt   = fdfc_pkg::RAW_FULL;
            ev_nxt        = fdfc_pkg::EV_LEASE_EXP;
          end
        end
      end
      fdfc_pkg::OP_SET: begin
        if (in_pct_r > 8'(fdfc_pkg::PCT_MAX)) begin
          ev_nxt = fdfc_pkg::EV_RANGE;
        end else if (!cfg.watchdog_ok && (set_val < fdfc_pkg::PCT_FULL)) begin
          setpoint_nxt  = fdfc_pkg::PCT_FULL;
          kick_pend_nxt = 1'b0;
          kick_el_nxt   = '0;
          applied_nxt   = fdfc_pkg::RAW_FULL;
          ev_nxt        = fdfc_pkg::EV_NO_WDOG;
        end else begin
          setpoint_nxt = set_val;
          if (set_val == '0) begin
            kick_pend_nxt = 1'b0;
            kick_el_nxt   = '0;
            applied_nxt   = fdfc_pkg::RAW_OFF;
          end else if (kick_pend_r) begin
            // retarget the running kick, timer keeps going
            kick_tgt_nxt = adj_raw;
          end else if (near_off && (cfg.kick_ticks != '0)) begin
            kick_pend_nxt = 1'b1;
            kick_el_nxt   = '0;
            kick_tgt_nxt  = adj_raw;
            applied_nxt   = kick_raw;
          end else begin
            applied_nxt   = adj_raw;
          end
          has_ctl_nxt  = 1'b1;
          lease_el_nxt = '0;
          failsafe_nxt = 1'b0;
          ev_nxt       = fdfc_pkg::EV_SET_OK;
        end
      end
      fdfc_pkg::OP_IDENT: begin
        ident_run_nxt = 1'b1;
        ident_el_nxt  = '0;
        blink_el_nxt  = '0;
        ident_led_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      applied_r   <= fdfc_pkg::RAW_FULL;
      setpoint_r  <= fdfc_pkg::PCT_FULL;
      kick_tgt_r  <= '0;
      kick_pend_r <= 1'b0;
      kick_el_r   <= '0;
      lease_el_r  <= '0;
      has_ctl_r   <= 1'b0;
      failsafe_r  <= 1'b1;
      ident_run_r <= 1'b0;
      ident_led_r <= 1'b0;
      ident_el_r  <= '0;
      blink_el_r  <= '0;
    end else if (advance) begin
      applied_r   <= applied_nxt;
      setpoint_r  <= setpoint_nxt;
      kick_tgt_r  <= kick_tgt_nxt;
      kick_pend_r <= kick_pend_nxt;
      kick_el_r   <= kick_el_nxt;
      lease_el_r  <= lease_el_nxt;
      has_ctl_r   <= has_ctl_nxt;
      failsafe_r  <= failsafe_nxt;
      ident_run_r <= ident_run_nxt;
      ident_led_r <= ident_led_nxt;
      ident_el_r  <= ident_el_nxt;
      blink_el_r  <= blink_el_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      event_r <= ev_nxt;
    end
  end

  // the state registers double as the result payload
  assign out_valid        = out_valid_r;
  assign out_applied_raw  = applied_r;
  assign out_demand_pct   = setpoint_r;
  assign out_failsafe_on  = failsafe_r;
  assign out_kick_on      = kick_pend_r;
  assign out_identify_on  = ident_run_r;
  assign out_identify_led = ident_led_r;
  assign out_event_code   = event_r;

`ifndef ASSERT_OFF
  a_kick_not_failsafe: assert property (@(posedge clk) disable iff (!rst_n)
    kick_pend_r |-> !failsafe_r)
    else $error("kick pending while in failsafe");

  a_failsafe_full: assert property (@(posedge clk) disable iff (!rst_n)
    failsafe_r |-> (setpoint_r == fdfc_pkg::PCT_FULL) && (applied_r == fdfc_pkg::RAW_FULL))
    else $error("failsafe without full speed");

  a_led_needs_ident: assert property (@(posedge clk) disable iff (!rst_n)
    ident_led_r |-> ident_run_r)
    else $error("identify LED on while identify idle");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(applied_r) && $stable(setpoint_r) && $stable(lease_el_r))
    else $error("state moved without a beat");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !advance)
    else $error("result overwritten while stalled");
`endif

endmodule

[src/fan_duty_failsafe_controller.sv]
// Top level of the fan duty failsafe controller.
//
// Usage:
//   in_if  : command beats (opcode 0 = 1 ms tick, 1 = set percent, 2 = identify).
//   out_if : one result beat per command: applied inverted PWM compare value,
//            requested percent, failsafe/kick/identify flags and an event code.
//   psel/penable/pwrite/paddr/pwdata/prdata/pready : APB-style register port,
//            register i at byte address 4*i; write only while no command is
//            in flight.
// Path: an accepted command goes into the input register; its result is
//   then written into the state/result register, which drives out_if.
// Throughput: one command per cycle when not stalled; state update is a single
//   pass of compares, increments and reciprocal multiplies for percent scaling.
// Reset (rst_n low, synchronous): state and config registers take their
//   defaults, fan is held at full speed with failsafe set, both channels empty.
// Receiver stall: the result holds on out_if; one more command is taken into
//   the input register, after which in_if.ready drops until the result drains.
module fan_duty_failsafe_controller (
  input  logic                        clk,
  input  logic                        rst_n,
  fdfc_in_if.sink                     in_if,
  fdfc_out_if.source                  out_if,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fdfc_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  fdfc_pkg::cfg_t cfg;

  fdfc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fdfc_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .in_valid         (in_if.valid),
    .in_ready         (in_if.ready),
    .in_opcode        (in_if.opcode),
    .in_percent       (in_if.percent_value),
    .out_valid        (out_if.valid),
    .out_ready        (out_if.ready),
    .out_applied_raw  (out_if.applied_raw),
    .out_demand_pct   (out_if.demand_pct),
    .out_failsafe_on  (out_if.failsafe_on),
    .out_kick_on      (out_if.kick_on),
    .out_identify_on  (out_if.identify_on),
    .out_identify_led (out_if.identify_led),
    .out_event_code   (out_if.event_code)
  );

endmodule
